// ----- hdl/rfdr_pkg.sv -----
// ----------------------------------------------------------------------------
// rfdr_pkg
// Shared types and constants for the receive frame descriptor ring.
// ----------------------------------------------------------------------------
package rfdr_pkg;

   localparam int BUF_BYTES_DEF  = 1024;
   localparam int RING_DEPTH_DEF = 16;

   localparam int LEN_W    = 10;
   localparam int REMAIN_W = 11;
   localparam int OFS_W    = 10;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 10'd255;

   localparam logic KIND_IDLE    = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic                kind;
      logic [REMAIN_W-1:0] dma_remaining;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFS_W-1:0]    frame_start;
      logic [OFS_W-1:0]    frame_end;
      logic [OFS_W-1:0]    restart_start;
   } rsp_type;

   typedef struct packed {
      logic [OFS_W-1:0] frame_start;
      logic [OFS_W-1:0] frame_end;
   } desc_type;

endpackage

// ----- hdl/rx_frame_descriptor_ring.sv -----
// An accepted request is registered in s1, its response in the rsp register.
// Throughput: one request per cycle while the response side keeps up; a stalled
// response holds the input register, which then stalls the request side.
// Reset: indices and write offset go to zero, max_frame_len to 255; the
// descriptor memory is not cleared.
// ----------------------------------------------------------------------------
// rx_frame_descriptor_ring
// Tracks received frames in a ring of descriptors over one receive buffer,
// driven by idle-line events and consumer releases.
// ----------------------------------------------------------------------------
module rx_frame_descriptor_ring #(
   parameter int BUF_BYTES  = rfdr_pkg::BUF_BYTES_DEF,
   parameter int RING_DEPTH = rfdr_pkg::RING_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rfdr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rfdr_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [rfdr_pkg::LEN_W-1:0]     csr_wr_data
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int OW = $clog2(BUF_BYTES + 1);
   localparam int SW = ((OW > rfdr_pkg::REMAIN_W) ? OW : rfdr_pkg::REMAIN_W) + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
   localparam logic [SW-1:0] BUF_END  = SW'(BUF_BYTES);

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
      logic [IW-1:0] nxt;
      if (idx == LAST_IDX) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

   logic [rfdr_pkg::LEN_W-1:0]    max_frame_len_ff;
   logic [OW-1:0]                 write_offset_ff, write_offset_in;
   logic [IW-1:0]                 in_index_ff, in_index_in;
   logic [IW-1:0]                 out_index_ff, out_index_in;
   logic                          s1_valid_ff, s1_valid_in;
   rfdr_pkg::req_type             s1_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rfdr_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   rfdr_pkg::desc_type            desc_mem [RING_DEPTH];
   rfdr_pkg::desc_type            head_ff;
   rfdr_pkg::desc_type            desc_wdata;
   logic                          desc_wr;

   logic                          out_free, s1_adv, req_acc;
   logic                          is_release, empty, ignored, full, fits;
   logic [rfdr_pkg::REMAIN_W-1:0] window, received;
   logic [SW-1:0]                 sum, new_off, end_off, room, wo_ext, restart_ext;
   logic [OW-1:0]                 restart_off;
   logic [IW-1:0]                 next_in;
   logic [rfdr_pkg::OFS_W-1:0]    start10, end10, restart10;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      is_release  = (s1_data_ff.kind == rfdr_pkg::KIND_RELEASE);
      empty       = (out_index_ff == in_index_ff);
      window      = {1'b0, max_frame_len_ff} + 11'd1;
      ignored     = (s1_data_ff.dma_remaining >= window);
      received    = window - s1_data_ff.dma_remaining;
      sum         = SW'(write_offset_ff) + SW'(received);
      new_off     = (sum > BUF_END) ? BUF_END : sum;
      end_off     = new_off - 1'b1;
      next_in     = ring_next(in_index_ff);
      full        = (next_in == out_index_ff);
      room        = BUF_END - new_off;
      fits        = (room > SW'(max_frame_len_ff));
      restart_off = fits ? new_off[OW-1:0] : '0;
      wo_ext      = SW'(write_offset_ff);
      restart_ext = SW'(restart_off);
      start10     = wo_ext[rfdr_pkg::OFS_W-1:0];
      end10       = end_off[rfdr_pkg::OFS_W-1:0];
      restart10   = restart_ext[rfdr_pkg::OFS_W-1:0];

      write_offset_in = write_offset_ff;
      in_index_in     = in_index_ff;
      out_index_in    = out_index_ff;
      desc_wr         = 1'b0;
      desc_wdata      = '{frame_start: start10, frame_end: end10};

      rsp_data_in               = '0;
      rsp_data_in.restart_start = start10;

      if (is_release) begin
         if (empty) begin
            rsp_data_in.status = rfdr_pkg::ST_EMPTY;
         end else begin
            rsp_data_in.status      = rfdr_pkg::ST_RELEASED;
            rsp_data_in.frame_start = head_ff.frame_start;
            rsp_data_in.frame_end   = head_ff.frame_end;
            if (s1_adv) begin
               out_index_in = ring_next(out_index_ff);
            end
         end
      end else if (ignored) begin
         rsp_data_in.status = rfdr_pkg::ST_IGNORED;
      end else if (full) begin
         // drop the frame and leave all state as it is
         rsp_data_in.status      = rfdr_pkg::ST_DROPPED;
         rsp_data_in.frame_start = start10;
         rsp_data_in.frame_end   = end10;
      end else begin
         rsp_data_in.status        = rfdr_pkg::ST_QUEUED;
         rsp_data_in.frame_start   = start10;
         rsp_data_in.frame_end     = end10;
         rsp_data_in.restart_start = restart10;
         if (s1_adv) begin
            desc_wr         = 1'b1;
            in_index_in     = next_in;
            write_offset_in = restart_off;
         end
      end

      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= rfdr_pkg::MAX_FRAME_LEN_RST;
         write_offset_ff  <= '0;
         in_index_ff      <= '0;
         out_index_ff     <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_frame_len_ff <= csr_wr_data;
         end
         write_offset_ff <= write_offset_in;
         in_index_ff     <= in_index_in;
         out_index_ff    <= out_index_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // head_ff always holds the descriptor at the next output index; forward a
   // same-cycle write to that entry
   always_ff @(posedge clock) begin
      if (desc_wr) begin
         desc_mem[in_index_ff] <= desc_wdata;
      end
      if (desc_wr && (in_index_ff == out_index_in)) begin
         head_ff <= desc_wdata;
      end else begin
         head_ff <= desc_mem[out_index_in];
      end
   end

endmodule

// ----- tb/rfdr_checker.sv -----
// ----------------------------------------------------------------------------
// rfdr_checker
// Watches the request, response and register ports of the descriptor ring,
// keeps its own copy of the ring state and compares every response with
// the outcome predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module rfdr_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  rfdr_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rfdr_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [rfdr_pkg::LEN_W-1:0] csr_wr_data,
   output int                         mismatches,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF   = rfdr_pkg::BUF_BYTES_DEF;
   localparam int DEPTH = rfdr_pkg::RING_DEPTH_DEF;

   logic [rfdr_pkg::LEN_W-1:0] frame_cap;
   int                         wr_ofs;
   int                         head_idx;
   int                         tail_idx;
   logic [rfdr_pkg::OFS_W-1:0] start_tab [DEPTH];
   logic [rfdr_pkg::OFS_W-1:0] end_tab [DEPTH];
   rfdr_pkg::rsp_type          outcome_q [$];
   int                         miss_cnt = 0;

   function automatic int ring_next(input int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   // Apply one request to the shadow ring and return the response it earns.
   function automatic rfdr_pkg::rsp_type ring_update(input rfdr_pkg::req_type item);
      rfdr_pkg::rsp_type r;
      int                win;
      int                got;
      int                sum;
      int                nxt;
      r = '0;
      win = int'(frame_cap) + 1;
      r.restart_start = start_tab[head_idx];
      if (item.kind == rfdr_pkg::KIND_RELEASE) begin
         if (tail_idx == head_idx) begin
            r.status = rfdr_pkg::ST_EMPTY;
         end else begin
            r.status      = rfdr_pkg::ST_RELEASED;
            r.frame_start = start_tab[tail_idx];
            r.frame_end   = end_tab[tail_idx];
            tail_idx      = ring_next(tail_idx);
         end
      end else if (int'(item.dma_remaining) >= win) begin
         r.status = rfdr_pkg::ST_IGNORED;
      end else begin
         got = win - int'(item.dma_remaining);
         sum = wr_ofs + got;
         // saturate at the buffer end after a window increase
         if (sum > BUF) begin
            sum = BUF;
         end
         nxt = ring_next(head_idx);
         r.frame_start = start_tab[head_idx];
         r.frame_end   = rfdr_pkg::OFS_W'(sum - 1);
         if (nxt == tail_idx) begin
            // ring full: drop the frame, leave the state alone
            r.status = rfdr_pkg::ST_DROPPED;
         end else begin
            r.status          = rfdr_pkg::ST_QUEUED;
            end_tab[head_idx] = rfdr_pkg::OFS_W'(sum - 1);
            if (BUF - sum > int'(frame_cap)) begin
               start_tab[nxt] = rfdr_pkg::OFS_W'(sum);
               wr_ofs         = sum;
            end else begin
               start_tab[nxt] = '0;
               wr_ofs         = 0;
            end
            head_idx        = nxt;
            r.restart_start = start_tab[nxt];
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name,
                              input logic [rfdr_pkg::OFS_W-1:0] want,
                              input logic [rfdr_pkg::OFS_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         miss_cnt++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rfdr_pkg::rsp_type want;
      if (reset) begin
         frame_cap = rfdr_pkg::MAX_FRAME_LEN_RST;
         wr_ofs    = 0;
         head_idx  = 0;
         tail_idx  = 0;
         foreach (start_tab[i]) begin
            start_tab[i] = '0;
            end_tab[i]   = '0;
         end
         outcome_q.delete();
      end else begin
         if (csr_wr_en) begin
            frame_cap = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               miss_cnt++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", rfdr_pkg::OFS_W'(want.status),
                           rfdr_pkg::OFS_W'(rsp_data.status));
               check_field("frame_start", want.frame_start, rsp_data.frame_start);
               check_field("frame_end", want.frame_end, rsp_data.frame_end);
               check_field("restart_start", want.restart_start, rsp_data.restart_start);
            end
         end
         if (req_valid && !req_stall) begin
            outcome_q.push_back(ring_update(req_data));
         end
      end
      mismatches <= miss_cnt;
      pending    <= outcome_q.size();
   end

endmodule

// ----- tb/rx_frame_descriptor_ring_tb.sv -----
// ----------------------------------------------------------------------------
// rx_frame_descriptor_ring_tb
// Drives idle-line events and descriptor releases into the ring under random
// idling on both channels, across several max_frame_len settings, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module rx_frame_descriptor_ring_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 3000;
   localparam int PHASE_ITEMS = 300;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   rfdr_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rfdr_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en;
   logic [rfdr_pkg::LEN_W-1:0] csr_wr_data;
   int                         mismatches;
   int                         pending;

   bit calm           = 1'b0;
   bit gaps_on        = 1'b1;
   bit long_hold_on   = 1'b0;
   bit long_hold_done = 1'b0;
   int sent_count     = 0;
   int cap            = 255;

   rx_frame_descriptor_ring u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rfdr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rfdr_pkg::req_type mk_req(input logic kind,
                                                input logic [rfdr_pkg::REMAIN_W-1:0] rem);
      rfdr_pkg::req_type t;
      t.kind          = kind;
      t.dma_remaining = rem;
      return t;
   endfunction

   // Mostly real frames inside the window; some empty windows and stray counts.
   function automatic rfdr_pkg::req_type random_event(input int win, input int release_pct);
      rfdr_pkg::req_type t;
      int                pick;
      t = '0;
      t.kind = ($urandom_range(0, 99) < release_pct) ? rfdr_pkg::KIND_RELEASE
                                                     : rfdr_pkg::KIND_IDLE;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         t.dma_remaining = rfdr_pkg::REMAIN_W'($urandom_range(0, win - 1));
      end else if (pick < 16) begin
         t.dma_remaining = rfdr_pkg::REMAIN_W'(win - 1);
      end else if (pick < 17) begin
         t.dma_remaining = '0;
      end else if (pick < 19) begin
         t.dma_remaining = rfdr_pkg::REMAIN_W'(win);
      end else begin
         t.dma_remaining = rfdr_pkg::REMAIN_W'($urandom_range(0, 2047));
      end
      return t;
   endfunction

   task automatic send_item(input rfdr_pkg::req_type item);
      if (!calm && !long_hold_on && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Hold the request side until every outstanding transaction has returned.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_cap(input int v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rfdr_pkg::LEN_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap = v;
   endtask

   initial begin : rsp_side
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!long_hold_done && sent_count >= 450) begin
            // back up the block until it stalls the request side
            long_hold_on = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold_on   = 1'b0;
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(60, 200)
                                              : $urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int caps [6];
      int release_pct;
      caps = '{255, 1023, 1, 700, 16, 0};
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty ring, empty windows, a full window and a one-byte frame
      send_item(mk_req(rfdr_pkg::KIND_RELEASE, 11'd0));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd256));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'h7FF));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd0));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd255));
      send_item(mk_req(rfdr_pkg::KIND_RELEASE, 11'h7FF));
      // leave the write offset mid-buffer, then widen the window past the end
      write_cap(511);
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd0));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd0));
      write_cap(1023);
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd0));
      send_item(mk_req(rfdr_pkg::KIND_IDLE, 11'd1024));
      // two-byte window: fill the ring, then one more frame is dropped
      write_cap(1);
      for (int k = 0; k < 12; k++) begin
         send_item(mk_req(rfdr_pkg::KIND_IDLE, (k % 2 == 1) ? 11'd1 : 11'd0));
      end
      send_item(mk_req(rfdr_pkg::KIND_RELEASE, 11'd0));
      send_item(mk_req(rfdr_pkg::KIND_RELEASE, 11'd0));

      for (int p = 0; p < 6; p++) begin
         write_cap(p == 5 ? $urandom_range(1, 1023) : caps[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) begin
               // swing between filling and draining the ring
               case ($urandom_range(0, 2))
                  0: begin
                     release_pct = 15;
                  end
                  1: begin
                     release_pct = 45;
                  end
                  default: begin
                     release_pct = 75;
                  end
               endcase
               gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (i == PHASE_ITEMS / 2) begin
               settle();
            end
            if (p == 5 && i == 150) begin
               calm = 1'b1;
            end
            send_item(random_event(cap + 1, release_pct));
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/rfdr_pkg.sv
hdl/rx_frame_descriptor_ring.sv
tb/rfdr_checker.sv
tb/rx_frame_descriptor_ring_tb.sv
